// ===== rtl/hcb_pkg.sv =====
// Shared types and constants for the Huffman code builder and encoder.
// No dependencies; every other file in rtl/ refers to this package by scope.
package hcb_pkg;

    localparam int SYM_W       = 8;
    localparam int FUNC_W      = 2;
    localparam int CODE_BITS_W = 32;
    localparam int CODE_LEN_W  = 6;
    localparam int FREQ_W      = 16;
    localparam int DIST_W      = 9;
    localparam int LANE_LEN_W  = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [FUNC_W-1:0] {
        FN_COUNT  = 2'd0,
        FN_BUILD  = 2'd1,
        FN_ENCODE = 2'd2,
        FN_CLEAR  = 2'd3
    } func_t;

    // Operation applied to all cells of the sorted node chain together.
    typedef enum logic [1:0] {
        CH_HOLD,
        CH_CLEAR,
        CH_INSERT,
        CH_MERGE
    } chain_cmd_t;

    // Control for the per-symbol code lanes.
    typedef struct packed {
        logic             init;
        logic             merge;
        logic             shift;
        logic [SYM_W-1:0] sym_a;
        logic [SYM_W-1:0] sym_b;
        logic [SYM_W-1:0] sym_m;
    } lane_ctl_t;

endpackage

// ===== rtl/hcb_cell.sv =====
// One cell of the sorted node chain: holds one live tree node key.
// Depends on hcb_pkg.
module hcb_cell #(
    parameter int KW = 24
) (
    input  logic                chan_clk_unused_guard,
    input  logic                clk,
    input  logic                rst_n,
    input  hcb_pkg::chain_cmd_t cmd,
    input  logic [KW-1:0]       new_key,
    input  logic                next2_vld,
    input  logic [KW-1:0]       next2_key,
    input  logic                prev_sh_vld,
    input  logic [KW-1:0]       prev_sh_key,
    input  logic                prev_lt,
    output logic                vld,
    output logic [KW-1:0]       key,
    output logic                sh_vld,
    output logic [KW-1:0]       sh_key,
    output logic                lt
);
    logic          vld_reg, vld_next;
    logic [KW-1:0] key_reg, key_next;
    logic          unused_guard;

    assign unused_guard = chan_clk_unused_guard;

    // A merge pops the two head cells, so every cell first looks two places on.
    always_comb
    begin
        if (cmd == hcb_pkg::CH_MERGE)
        begin
            sh_vld = next2_vld;
            sh_key = next2_key;
        end
        else
        begin
            sh_vld = vld_reg;
            sh_key = key_reg;
        end
        lt = !sh_vld || (new_key < sh_key) || unused_guard;
    end

    always_comb
    begin
        vld_next = vld_reg;
        key_next = key_reg;
        case (cmd)
            hcb_pkg::CH_CLEAR:
            begin
                vld_next = 1'b0;
            end
            hcb_pkg::CH_INSERT, hcb_pkg::CH_MERGE:
            begin
                if (lt)
                begin
                    if (prev_lt)
                    begin
                        vld_next = prev_sh_vld;
                        key_next = prev_sh_key;
                    end
                    else
                    begin
                        vld_next = 1'b1;
                        key_next = new_key;
                    end
                end
                else
                begin
                    vld_next = sh_vld;
                    key_next = sh_key;
                end
            end
            default:
            begin
                vld_next = vld_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign vld = vld_reg;
    assign key = key_reg;

endmodule

// ===== rtl/hcb_chain.sv =====
// Sorted chain of node cells, smallest key at cell 0.
// Depends on hcb_pkg and hcb_cell.
module hcb_chain #(
    parameter int N  = 256,
    parameter int KW = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hcb_pkg::chain_cmd_t cmd,
    input  logic [KW-1:0]       new_key,
    output logic                head0_vld,
    output logic [KW-1:0]       head0_key,
    output logic                head1_vld,
    output logic [KW-1:0]       head1_key
);
    logic          vld_w    [N];
    logic [KW-1:0] key_w    [N];
    logic          sh_vld_w [N];
    logic [KW-1:0] sh_key_w [N];
    logic          lt_w     [N];

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic          n2_vld;
        logic [KW-1:0] n2_key;
        logic          p_vld;
        logic [KW-1:0] p_key;
        logic          p_lt;

        if (i + 2 < N)
        begin : g_n2
            assign n2_vld = vld_w[i+2];
            assign n2_key = key_w[i+2];
        end
        else
        begin : g_n2_end
            assign n2_vld = 1'b0;
            assign n2_key = '0;
        end

        if (i > 0)
        begin : g_prev
            assign p_vld = sh_vld_w[i-1];
            assign p_key = sh_key_w[i-1];
            assign p_lt  = lt_w[i-1];
        end
        else
        begin : g_prev_head
            assign p_vld = 1'b0;
            assign p_key = '0;
            assign p_lt  = 1'b0;
        end

        hcb_cell #(
            .KW(KW)
        ) u_cell (
            .chan_clk_unused_guard(1'b0),
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .new_key     (new_key),
            .next2_vld   (n2_vld),
            .next2_key   (n2_key),
            .prev_sh_vld (p_vld),
            .prev_sh_key (p_key),
            .prev_lt     (p_lt),
            .vld         (vld_w[i]),
            .key         (key_w[i]),
            .sh_vld      (sh_vld_w[i]),
            .sh_key      (sh_key_w[i]),
            .lt          (lt_w[i])
        );
    end

    assign head0_vld = vld_w[0];
    assign head0_key = key_w[0];
    assign head1_vld = vld_w[1];
    assign head1_key = key_w[1];

endmodule

// ===== rtl/hcb_lanes.sv =====
// Per-symbol code lanes: group label, code length and code bits of each symbol.
// Depends on hcb_pkg. Lanes shift toward lane 0 to be written out.
module hcb_lanes #(
    parameter int ALPHABET = 256,
    parameter int CL       = 32
) (
    input  logic                              clk,
    input  hcb_pkg::lane_ctl_t                ctl,
    output logic [hcb_pkg::LANE_LEN_W-1:0]    out_len,
    output logic [CL-1:0]                     out_bits
);
    logic [hcb_pkg::SYM_W-1:0]      grp_reg  [ALPHABET];
    logic [hcb_pkg::LANE_LEN_W-1:0] len_reg  [ALPHABET];
    logic [CL-1:0]                  bits_reg [ALPHABET];

    for (genvar i = 0; i < ALPHABET; i++)
    begin : g_lane
        logic [hcb_pkg::SYM_W-1:0]      grp_next;
        logic [hcb_pkg::LANE_LEN_W-1:0] len_next;
        logic [CL-1:0]                  bits_next;

        always_comb
        begin
            grp_next  = grp_reg[i];
            len_next  = len_reg[i];
            bits_next = bits_reg[i];
            if (ctl.init)
            begin
                grp_next  = hcb_pkg::SYM_W'(i);
                len_next  = '0;
                bits_next = '0;
            end
            else if (ctl.merge)
            begin
                // The 0 branch leaves its bit clear; the 1 branch sets it.
                if (grp_reg[i] == ctl.sym_a)
                begin
                    len_next = len_reg[i] + 1'b1;
                    grp_next = ctl.sym_m;
                end
                else if (grp_reg[i] == ctl.sym_b)
                begin
                    bits_next = bits_reg[i] | (CL'(1) << len_reg[i]);
                    len_next  = len_reg[i] + 1'b1;
                    grp_next  = ctl.sym_m;
                end
            end
            else if (ctl.shift)
            begin
                if (i + 1 < ALPHABET)
                begin
                    grp_next  = grp_reg[(i+1) % ALPHABET];
                    len_next  = len_reg[(i+1) % ALPHABET];
                    bits_next = bits_reg[(i+1) % ALPHABET];
                end
                else
                begin
                    len_next  = '0;
                    bits_next = '0;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            grp_reg[i]  <= grp_next;
            len_reg[i]  <= len_next;
            bits_reg[i] <= bits_next;
        end
    end

    assign out_len  = len_reg[0];
    assign out_bits = bits_reg[0];

endmodule

// ===== rtl/huffman_code_builder_encoder.sv =====
// Top level of the static Huffman code builder and encoder over bytes.
// Depends on hcb_pkg, hcb_chain (with hcb_cell) and hcb_lanes.
//
// Usage: one input transaction per item on the s_axis channel; s_axis_tuser
// carries the function (count, build, encode, clear) and s_axis_tdata the
// symbol. Every item gives exactly one result transaction on m_axis.
// Count, encode and clear items pass through S_IDLE, S_EXEC and S_RESP: the
// accept cycle reads the histogram and code memories, S_EXEC executes and forms
// the result, S_RESP places it in the output register. s_axis_tready is high
// only in S_IDLE, so a new item is accepted only once the last one has left S_RESP.
// A build item sweeps the histogram, inserting each nonzero count as a leaf
// into a sorted chain of cells, then merges the two head cells once per
// cycle, then shifts the code lanes out into the code memory.
// Reset clears the histogram valid bits, counters and flags at once; no
// clearing pass is needed. If the receiver stalls, the finished result holds
// in the output register; the block may still take and execute one more item,
// which then waits until the output register frees up.
module huffman_code_builder_encoder #(
    parameter int ALPHABET    = 256,
    parameter int COUNT_WIDTH = 16,
    parameter int CODE_WIDTH  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: symbol[7:0].
    input  logic [hcb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: func[1:0].
    input  logic [hcb_pkg::FUNC_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: code_bits[31:0], code_length[37:32],
    // symbol_frequency[53:38], distinct_symbols[62:54], count_overflow[63],
    // codes_ready[64], zero fill[71:65].
    output logic [hcb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    localparam int AW  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int DW  = $clog2(ALPHABET + 1);
    localparam int KW  = COUNT_WIDTH + hcb_pkg::SYM_W;
    localparam int CL  = (CODE_WIDTH < 32) ? CODE_WIDTH : 32;
    localparam int CEW = CL + hcb_pkg::CODE_LEN_W;
    localparam logic [AW:0]              ALPHA_CNT = (AW + 1)'(ALPHABET);
    localparam logic [hcb_pkg::SYM_W:0]  ALPHA_SYM = (hcb_pkg::SYM_W + 1)'(ALPHABET);
    localparam logic [COUNT_WIDTH-1:0]   COUNT_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RESP,
        S_FILL,
        S_MERGE,
        S_WRITE
    } state_t;

    // Control and status registers.
    state_t                      state_reg, state_next;
    hcb_pkg::func_t              func_reg, func_next;
    logic [hcb_pkg::SYM_W-1:0]   sym_reg, sym_next;
    logic [COUNT_WIDTH-1:0]      total_reg, total_next;
    logic                        ovf_reg, ovf_next;
    logic                        ready_reg, ready_next;
    logic [DW-1:0]               distinct_reg, distinct_next;
    logic [DW-1:0]               nleaf_reg, nleaf_next;
    logic [DW-1:0]               nlive_reg, nlive_next;
    logic [AW:0]                 cnt_reg, cnt_next;
    logic                        pend_reg, pend_next;
    logic [AW-1:0]               psym_reg, psym_next;
    logic [hcb_pkg::OUT_TDATA_W-1:0] res_reg, res_next;
    logic                        mv_reg, mv_next;
    logic [hcb_pkg::OUT_TDATA_W-1:0] mdata_reg, mdata_next;
    logic [ALPHABET-1:0]         hvalid_reg;

    // Memories and their registered read data.
    logic [COUNT_WIDTH-1:0]      hist_mem [ALPHABET];
    logic [CEW-1:0]              code_mem [ALPHABET];
    logic [COUNT_WIDTH-1:0]      hist_rd_reg;
    logic                        hvld_rd_reg;
    logic [CEW-1:0]              code_rd_reg;

    logic                        accept;
    logic [AW-1:0]               rd_addr;
    logic                        hist_we;
    logic [AW-1:0]               hist_wa;
    logic [COUNT_WIDTH-1:0]      hist_wd;
    logic                        code_we;
    logic [CEW-1:0]              code_wd;
    logic                        clear_all;
    logic [COUNT_WIDTH-1:0]      h_val;
    logic                        in_alpha;
    logic [hcb_pkg::SYM_W-1:0]   psym8;

    hcb_pkg::chain_cmd_t         ch_cmd;
    logic [KW-1:0]               ch_key;
    logic                        h0_vld, h1_vld;
    logic [KW-1:0]               h0_key, h1_key;
    hcb_pkg::lane_ctl_t          lane_ctl;
    logic [hcb_pkg::LANE_LEN_W-1:0] lane_len;
    logic [CL-1:0]               lane_bits;

    logic [hcb_pkg::CODE_BITS_W-1:0] r_bits;
    logic [hcb_pkg::CODE_LEN_W-1:0]  r_len;
    logic [COUNT_WIDTH-1:0]          r_freq;
    logic [COUNT_WIDTH-1:0]          m_freq;
    logic [hcb_pkg::SYM_W-1:0]       m_sym;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = mdata_reg;

    assign rd_addr  = (state_reg == S_FILL) ? cnt_reg[AW-1:0] : s_axis_tdata[AW-1:0];
    assign h_val    = hvld_rd_reg ? hist_rd_reg : '0;
    assign in_alpha = ({1'b0, sym_reg} < ALPHA_SYM);
    assign psym8    = hcb_pkg::SYM_W'(psym_reg);

    // Node key: frequency, then symbol read as a signed byte (top bit flipped).
    assign m_freq = h0_key[KW-1:hcb_pkg::SYM_W] + h1_key[KW-1:hcb_pkg::SYM_W];
    assign m_sym  = (h0_key[hcb_pkg::SYM_W-1:0] < h1_key[hcb_pkg::SYM_W-1:0])
                    ? h0_key[hcb_pkg::SYM_W-1:0] : h1_key[hcb_pkg::SYM_W-1:0];

    hcb_chain #(
        .N  (ALPHABET),
        .KW (KW)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ch_cmd),
        .new_key   (ch_key),
        .head0_vld (h0_vld),
        .head0_key (h0_key),
        .head1_vld (h1_vld),
        .head1_key (h1_key)
    );

    hcb_lanes #(
        .ALPHABET (ALPHABET),
        .CL       (CL)
    ) u_lanes (
        .clk      (clk),
        .ctl      (lane_ctl),
        .out_len  (lane_len),
        .out_bits (lane_bits)
    );

    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        sym_next      = sym_reg;
        total_next    = total_reg;
        ovf_next      = ovf_reg;
        ready_next    = ready_reg;
        distinct_next = distinct_reg;
        nleaf_next    = nleaf_reg;
        nlive_next    = nlive_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        psym_next     = psym_reg;
        res_next      = res_reg;
        mv_next       = mv_reg;
        mdata_next    = mdata_reg;
        hist_we       = 1'b0;
        hist_wa       = sym_reg[AW-1:0];
        hist_wd       = h_val + 1'b1;
        code_we       = 1'b0;
        code_wd       = '0;
        clear_all     = 1'b0;
        ch_cmd        = hcb_pkg::CH_HOLD;
        ch_key        = {m_freq, m_sym};
        lane_ctl      = '0;
        lane_ctl.sym_a = {~h0_key[hcb_pkg::SYM_W-1], h0_key[hcb_pkg::SYM_W-2:0]};
        lane_ctl.sym_b = {~h1_key[hcb_pkg::SYM_W-1], h1_key[hcb_pkg::SYM_W-2:0]};
        lane_ctl.sym_m = {~m_sym[hcb_pkg::SYM_W-1], m_sym[hcb_pkg::SYM_W-2:0]};
        r_bits        = '0;
        r_len         = '0;
        r_freq        = '0;

        if (mv_reg && m_axis_tready)
        begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next = hcb_pkg::func_t'(s_axis_tuser);
                    sym_next  = s_axis_tdata[hcb_pkg::SYM_W-1:0];
                    if (hcb_pkg::func_t'(s_axis_tuser) == hcb_pkg::FN_BUILD)
                    begin
                        ch_cmd        = hcb_pkg::CH_CLEAR;
                        lane_ctl.init = 1'b1;
                        cnt_next      = '0;
                        pend_next     = 1'b0;
                        nleaf_next    = '0;
                        state_next    = S_FILL;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                case (func_reg)
                    hcb_pkg::FN_COUNT:
                    begin
                        ready_next = 1'b0;
                        if (in_alpha)
                        begin
                            r_freq = h_val;
                            if (total_reg == COUNT_MAX)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                total_next = total_reg + 1'b1;
                                hist_we    = 1'b1;
                                r_freq     = h_val + 1'b1;
                                if (h_val == '0)
                                begin
                                    distinct_next = distinct_reg + 1'b1;
                                end
                            end
                        end
                    end
                    hcb_pkg::FN_ENCODE:
                    begin
                        if (in_alpha)
                        begin
                            r_freq = h_val;
                            if (ready_reg)
                            begin
                                r_bits = hcb_pkg::CODE_BITS_W'(code_rd_reg[CEW-1:hcb_pkg::CODE_LEN_W]);
                                r_len  = code_rd_reg[hcb_pkg::CODE_LEN_W-1:0];
                            end
                        end
                    end
                    hcb_pkg::FN_CLEAR:
                    begin
                        clear_all     = 1'b1;
                        total_next    = '0;
                        ovf_next      = 1'b0;
                        ready_next    = 1'b0;
                        distinct_next = '0;
                    end
                    default:
                    begin
                        r_freq = '0;
                    end
                endcase
                res_next = hcb_pkg::OUT_TDATA_W'({ready_next, ovf_next,
                           hcb_pkg::DIST_W'(distinct_next),
                           hcb_pkg::FREQ_W'(r_freq), r_len, r_bits});
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!mv_reg || m_axis_tready)
                begin
                    mv_next    = 1'b1;
                    mdata_next = res_reg;
                    state_next = S_IDLE;
                end
            end
            S_FILL:
            begin
                // Leaf insertion happens in the cycle after the histogram read, from the registered read data.
                if (pend_reg && (h_val != '0))
                begin
                    ch_cmd     = hcb_pkg::CH_INSERT;
                    ch_key     = {h_val, ~psym8[hcb_pkg::SYM_W-1], psym8[hcb_pkg::SYM_W-2:0]};
                    nleaf_next = nleaf_reg + 1'b1;
                end
                if (cnt_reg < ALPHA_CNT)
                begin
                    pend_next = 1'b1;
                    psym_next = cnt_reg[AW-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        nlive_next = nleaf_reg;
                        state_next = S_MERGE;
                    end
                end
            end
            S_MERGE:
            begin
                if (nlive_reg > DW'(1))
                begin
                    ch_cmd         = hcb_pkg::CH_MERGE;
                    lane_ctl.merge = 1'b1;
                    nlive_next     = nlive_reg - 1'b1;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                lane_ctl.shift = 1'b1;
                code_we        = 1'b1;
                // A lone symbol and over-long codes get length 0.
                if ((nleaf_reg > DW'(1)) &&
                    (lane_len <= hcb_pkg::LANE_LEN_W'(CL)))
                begin
                    code_wd = {lane_bits, hcb_pkg::CODE_LEN_W'(lane_len)};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ALPHA_CNT - 1'b1)
                begin
                    ready_next = 1'b1;
                    res_next   = hcb_pkg::OUT_TDATA_W'({1'b1, ovf_reg,
                                 hcb_pkg::DIST_W'(distinct_reg),
                                 hcb_pkg::FREQ_W'(0),
                                 hcb_pkg::CODE_LEN_W'(0),
                                 hcb_pkg::CODE_BITS_W'(0)});
                    state_next = S_RESP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            func_reg     <= hcb_pkg::FN_COUNT;
            total_reg    <= '0;
            ovf_reg      <= 1'b0;
            ready_reg    <= 1'b0;
            distinct_reg <= '0;
            nleaf_reg    <= '0;
            nlive_reg    <= '0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            mv_reg       <= 1'b0;
            hvalid_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            func_reg     <= func_next;
            total_reg    <= total_next;
            ovf_reg      <= ovf_next;
            ready_reg    <= ready_next;
            distinct_reg <= distinct_next;
            nleaf_reg    <= nleaf_next;
            nlive_reg    <= nlive_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            mv_reg       <= mv_next;
            if (clear_all)
            begin
                hvalid_reg <= '0;
            end
            else if (hist_we)
            begin
                hvalid_reg[hist_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg     <= sym_next;
        psym_reg    <= psym_next;
        res_reg     <= res_next;
        mdata_reg   <= mdata_next;
        hist_rd_reg <= hist_mem[rd_addr];
        hvld_rd_reg <= hvalid_reg[rd_addr];
        code_rd_reg <= code_mem[rd_addr];
        if (hist_we)
        begin
            hist_mem[hist_wa] <= hist_wd;
        end
        if (code_we)
        begin
            code_mem[cnt_reg[AW-1:0]] <= code_wd;
        end
    end

    // The two head cells of the chain stay sorted with distinct keys.
    assert property (@(posedge clk) disable iff (!rst_n)
        h1_vld |-> (h0_vld && (h0_key < h1_key)))
        else $error("node chain out of order");

    // Every merge finds two live nodes at the head of the chain.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MERGE) && (nlive_reg > DW'(1))) |-> (h0_vld && h1_vld))
        else $error("merge without two live nodes");

    // The distinct symbol count never exceeds the alphabet.
    assert property (@(posedge clk) disable iff (!rst_n)
        (distinct_reg <= DW'(ALPHABET)))
        else $error("distinct symbol count out of range");

endmodule

// ===== tb/huffman_code_builder_encoder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the static Huffman code builder and encoder.
// Depends on hcb_pkg and the huffman_code_builder_encoder top level only.
module huffman_code_builder_encoder_tb;

    typedef struct {
        hcb_pkg::func_t fn;
        logic [7:0]     sym;
    } huff_item_t;

    typedef struct {
        logic [31:0] bits;
        logic [5:0]  len;
        logic [15:0] freq;
        logic [8:0]  ndist;
        logic        ovf;
        logic        rdy;
    } huff_result_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 300;
    localparam int COUNT_LIMIT    = 65535;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [hcb_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [hcb_pkg::FUNC_W-1:0]      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [hcb_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    huff_item_t   pending_items[$];
    huff_result_t expected_codes[$];
    int  errors = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  builds_seen = 0;
    int  hold_req = 0;
    bit  quiet = 1'b0;

    // Predictor state.
    int              hist[256];
    int              total_cnt;
    bit              ovf_flag;
    bit              ready_flag;
    longint unsigned tab_bits[256];
    int              tab_len[256];
    int              nfreq[511];
    logic [7:0]      nsym[511];

    always #5 clk = ~clk;

    huffman_code_builder_encoder DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Sort key: frequency first, then the symbol read as a signed byte.
    function automatic longint node_key(int n);
        return (longint'(nfreq[n]) << 8) | longint'(nsym[n] ^ 8'h80);
    endfunction

    function automatic int distinct_count();
        int d;
        d = 0;
        for (int s = 0; s < 256; s++)
            if (hist[s] != 0) d++;
        return d;
    endfunction

    function automatic void clear_model();
        for (int s = 0; s < 256; s++)
        begin
            hist[s] = 0;
            tab_bits[s] = 0;
            tab_len[s] = 0;
        end
        total_cnt = 0;
        ovf_flag = 1'b0;
        ready_flag = 1'b0;
    endfunction

    // Repeatedly merges the two smallest live nodes, then walks each leaf up to the root.
    function automatic void build_code_table();
        int live[256];
        int parent[511];
        int branch[511];
        int leaf_sym[256];
        int nleaf, nlive, nnodes, p0, p1, a, b, m, t, n, len;
        longint k;
        longint unsigned bits;
        nleaf = 0;
        for (int s = 0; s < 256; s++)
        begin
            tab_bits[s] = 0;
            tab_len[s] = 0;
            if (hist[s] != 0)
            begin
                nfreq[nleaf] = hist[s];
                nsym[nleaf] = s[7:0];
                leaf_sym[nleaf] = s;
                live[nleaf] = nleaf;
                nleaf++;
            end
        end
        nlive = nleaf;
        nnodes = nleaf;
        while (nlive > 1)
        begin
            p0 = 0;
            p1 = 1;
            if (node_key(live[1]) < node_key(live[0]))
            begin
                p0 = 1;
                p1 = 0;
            end
            for (int i = 2; i < nlive; i++)
            begin
                k = node_key(live[i]);
                if (k < node_key(live[p0]))
                begin
                    p1 = p0;
                    p0 = i;
                end
                else if (k < node_key(live[p1]))
                    p1 = i;
            end
            a = live[p0];
            b = live[p1];
            m = nnodes++;
            nfreq[m] = nfreq[a] + nfreq[b];
            nsym[m] = ((nsym[a] ^ 8'h80) < (nsym[b] ^ 8'h80)) ? nsym[a] : nsym[b];
            parent[a] = m;
            branch[a] = 0;
            parent[b] = m;
            branch[b] = 1;
            if (p0 > p1)
            begin
                t = p0;
                p0 = p1;
                p1 = t;
            end
            live[p1] = live[nlive-1];
            nlive--;
            live[p0] = live[nlive-1];
            nlive--;
            live[nlive++] = m;
        end
        if (nleaf > 1)
        begin
            for (int i = 0; i < nleaf; i++)
            begin
                n = i;
                len = 0;
                bits = 0;
                while (n != nnodes - 1)
                begin
                    if (len < 64) bits |= longint'(branch[n]) << len;
                    len++;
                    n = parent[n];
                end
                if (len <= 32)
                begin
                    tab_bits[leaf_sym[i]] = bits;
                    tab_len[leaf_sym[i]] = len;
                end
            end
        end
        ready_flag = 1'b1;
    endfunction

    // Applies one accepted item to the predictor and queues the result it must produce.
    function automatic void predict_code(huff_item_t it);
        huff_result_t r;
        r.bits = '0;
        r.len = '0;
        r.freq = '0;
        case (it.fn)
            hcb_pkg::FN_COUNT:
            begin
                ready_flag = 1'b0;
                if (total_cnt >= COUNT_LIMIT)
                    ovf_flag = 1'b1;
                else
                begin
                    total_cnt++;
                    hist[it.sym]++;
                end
                r.freq = hist[it.sym][15:0];
            end
            hcb_pkg::FN_BUILD: build_code_table();
            hcb_pkg::FN_ENCODE:
            begin
                r.freq = hist[it.sym][15:0];
                if (ready_flag)
                begin
                    r.bits = tab_bits[it.sym][31:0];
                    r.len = tab_len[it.sym][5:0];
                end
            end
            default: clear_model();
        endcase
        r.ndist = distinct_count();
        r.ovf = ovf_flag;
        r.rdy = ready_flag;
        expected_codes.insert(expected_codes.size(), r);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on result %0d: %s got 0x%0h, want 0x%0h",
                 results_seen, what, got, want);
        errors++;
    endtask

    task automatic put_item(hcb_pkg::func_t fn, int sym);
        huff_item_t it;
        it.fn = fn;
        it.sym = sym[7:0];
        pending_items.insert(pending_items.size(), it);
    endtask

    // Waits until every queued item has gone in and every result has come back.
    task automatic wait_drain();
        do @(posedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_codes.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Driver: presents queued items, with random bursts of idle cycles between them.
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        huff_item_t it;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                it.fn = hcb_pkg::func_t'(s_axis_tuser);
                it.sym = s_axis_tdata;
                predict_code(it);
                items_sent++;
                if (it.fn == hcb_pkg::FN_BUILD) builds_seen++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap == 0 && !quiet && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 9);
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    it = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= it.sym;
                    s_axis_tuser <= it.fn;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transaction against the oldest prediction and
    // throttles m_axis_tready, including one long hold-off on request.
    int rx_gap = 0;
    int hold_seen = 0;
    always @(posedge clk or negedge rst_n)
    begin
        huff_result_t w;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_codes.size() == 0)
                    report_mismatch("unexpected result", m_axis_tdata[63:0], 0);
                else
                begin
                    w = expected_codes.pop_front();
                    if (m_axis_tdata[31:0] !== w.bits)
                        report_mismatch("code_bits", m_axis_tdata[31:0], w.bits);
                    if (m_axis_tdata[37:32] !== w.len)
                        report_mismatch("code_length", m_axis_tdata[37:32], w.len);
                    if (m_axis_tdata[53:38] !== w.freq)
                        report_mismatch("symbol_frequency", m_axis_tdata[53:38], w.freq);
                    if (m_axis_tdata[62:54] !== w.ndist)
                        report_mismatch("distinct_symbols", m_axis_tdata[62:54], w.ndist);
                    if (m_axis_tdata[63] !== w.ovf)
                        report_mismatch("count_overflow", m_axis_tdata[63], w.ovf);
                    if (m_axis_tdata[64] !== w.rdy)
                        report_mismatch("codes_ready", m_axis_tdata[64], w.rdy);
                end
                results_seen++;
            end
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                rx_gap = HOLD_CYCLES;
            end
            else if (rx_gap == 0 && !quiet && $urandom_range(0, 7) == 0)
                rx_gap = $urandom_range(1, 9);
            if (rx_gap > 0)
            begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction on either side.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int set_syms[8];
        int nset, ncount, fa, fb, fc;
        clear_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: encode before any build, an empty build, extremes of the symbol,
        // a lone symbol, a count after a build, and a repeated build.
        put_item(hcb_pkg::FN_ENCODE, 8'h00);
        put_item(hcb_pkg::FN_BUILD, 8'hff);
        put_item(hcb_pkg::FN_ENCODE, 8'hff);
        put_item(hcb_pkg::FN_COUNT, 8'h00);
        put_item(hcb_pkg::FN_COUNT, 8'hff);
        put_item(hcb_pkg::FN_COUNT, 8'h7f);
        put_item(hcb_pkg::FN_COUNT, 8'h80);
        put_item(hcb_pkg::FN_COUNT, 8'h80);
        put_item(hcb_pkg::FN_BUILD, 8'h00);
        put_item(hcb_pkg::FN_ENCODE, 8'h00);
        put_item(hcb_pkg::FN_ENCODE, 8'hff);
        put_item(hcb_pkg::FN_ENCODE, 8'h7f);
        put_item(hcb_pkg::FN_ENCODE, 8'h80);
        put_item(hcb_pkg::FN_ENCODE, 8'h55);
        put_item(hcb_pkg::FN_BUILD, 8'haa);
        put_item(hcb_pkg::FN_ENCODE, 8'h80);
        put_item(hcb_pkg::FN_COUNT, 8'h7f);
        put_item(hcb_pkg::FN_ENCODE, 8'h7f);
        put_item(hcb_pkg::FN_CLEAR, 8'h12);
        put_item(hcb_pkg::FN_COUNT, 8'h42);
        put_item(hcb_pkg::FN_BUILD, 8'h00);
        put_item(hcb_pkg::FN_ENCODE, 8'h42);
        put_item(hcb_pkg::FN_CLEAR, 8'h00);
        wait_drain();

        // Random part: mostly clear / count / build / encode jobs over small alphabets.
        for (int job = 0; items_sent < 520; job++)
        begin
            nset = $urandom_range(1, 8);
            for (int i = 0; i < nset; i++) set_syms[i] = $urandom_range(0, 255);
            if ($urandom_range(0, 2) != 0)
                put_item(hcb_pkg::FN_CLEAR, $urandom_range(0, 255));
            ncount = $urandom_range(0, 30);
            for (int i = 0; i < ncount; i++)
                put_item(hcb_pkg::FN_COUNT, set_syms[$urandom_range(0, nset - 1)]);
            put_item(hcb_pkg::FN_BUILD, $urandom_range(0, 255));
            if ($urandom_range(0, 4) == 0)
                put_item(hcb_pkg::FN_BUILD, $urandom_range(0, 255));
            for (int i = 0; i < 8; i++)
                put_item(hcb_pkg::FN_ENCODE,
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : set_syms[$urandom_range(0, nset - 1)]);
            if ($urandom_range(0, 4) == 0)
            begin
                for (int i = 0; i < 5; i++)
                    put_item(hcb_pkg::func_t'($urandom_range(0, 3)), $urandom_range(0, 255));
            end
            if (job == 6)
            begin
                // Long receiver hold-off while the sender keeps offering.
                hold_req++;
                for (int i = 0; i < 20; i++)
                    put_item(hcb_pkg::FN_COUNT, $urandom_range(0, 255));
            end
            do @(posedge clk);
            while (pending_items.size() != 0);
            if (job % 5 == 4) wait_drain();
        end
        quiet = 1'b1;
        wait_drain();
        repeat (10) @(posedge clk);

        // Last part, no idling: Fibonacci counts give a deep, lopsided code tree.
        put_item(hcb_pkg::FN_CLEAR, 0);
        fa = 1;
        fb = 1;
        for (int i = 0; i < 12; i++)
        begin
            for (int j = 0; j < fa; j++) put_item(hcb_pkg::FN_COUNT, (i * 37 + 5) % 256);
            fc = fa + fb;
            fa = fb;
            fb = fc;
            do @(posedge clk);
            while (pending_items.size() > 64);
        end
        put_item(hcb_pkg::FN_BUILD, 0);
        for (int i = 0; i < 12; i++) put_item(hcb_pkg::FN_ENCODE, (i * 37 + 5) % 256);
        for (int s = 0; s < 256; s += 17) put_item(hcb_pkg::FN_ENCODE, s);
        put_item(hcb_pkg::FN_COUNT, 5);
        put_item(hcb_pkg::FN_ENCODE, 5);
        put_item(hcb_pkg::FN_BUILD, 0);
        put_item(hcb_pkg::FN_ENCODE, 5);
        put_item(hcb_pkg::FN_CLEAR, 0);
        put_item(hcb_pkg::FN_ENCODE, 0);
        wait_drain();
        repeat (20) @(posedge clk);

        $display("Covered %0d items (%0d builds) and %0d results, including deep codes,",
                 items_sent, builds_seen, results_seen);
        $display("lone and absent symbols, a long output stall and random idling on both sides.");
        if (errors == 0 && expected_codes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hcb_pkg.sv
rtl/hcb_cell.sv
rtl/hcb_chain.sv
rtl/hcb_lanes.sv
rtl/huffman_code_builder_encoder.sv
tb/huffman_code_builder_encoder_tb.sv
